@@ rtl/core/ntrp_pkg.sv @@
// shared types and constants of the ndef text record parser
package ntrp_pkg;

	localparam int MAX_LANG_LEN_DEF = 8;
	localparam int CFG_W            = 16;
	localparam int CFG_IDX_W        = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE   = 1'b1;

	localparam logic [15:0] CAPACITY_RST      = 16'd0;
	localparam logic [7:0]  EXPECTED_TYPE_RST = 8'h54;

	localparam logic [1:0] TNF_WELL_KNOWN = 2'b01;
	localparam logic [7:0] TYPE_LEN_ONE   = 8'h01;

	localparam logic [2:0] CL_FRAME   = 3'd0;
	localparam logic [2:0] CL_LANG    = 3'd1;
	localparam logic [2:0] CL_STORED  = 3'd2;
	localparam logic [2:0] CL_DISCARD = 3'd3;
	localparam logic [2:0] CL_REJECT  = 3'd4;
	localparam logic [2:0] CL_END     = 3'd5;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_NO_BUFFER  = 4'd1;
	localparam logic [3:0] ERR_BAD_HEADER = 4'd2;
	localparam logic [3:0] ERR_TYPE_LEN   = 4'd3;
	localparam logic [3:0] ERR_TYPE       = 4'd4;
	localparam logic [3:0] ERR_STATUS     = 4'd5;
	localparam logic [3:0] ERR_LANG_LONG  = 4'd6;
	localparam logic [3:0] ERR_EARLY_END  = 4'd7;
	localparam logic [3:0] ERR_LEN_SHORT  = 4'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  byte_class;
		logic [7:0]  out_byte;
		logic [15:0] position;
		logic        record_done;
		logic [3:0]  error_code;
		logic [15:0] stored_count;
		logic        utf16_text;
		logic [3:0]  language_length;
	} out_word_t;

endpackage

@@ rtl/core/ndef_text_record_parser_core.sv @@
// ndef text record parser: byte-wise header, length, type, status, language and payload parsing
//
// input channel: in_valid/in_stall carry one word per stream byte, or an end-of-stream
// word when stream_end is set (its data byte is then ignored).
// output channel: out_valid/out_stall return exactly one result word per input word,
// in order: byte class, echoed byte, buffer position, completion and error code, plus
// the running stored count and the accepted status fields.
// out_valid rises once the result register loads: the input register loads at the accepting edge,
// and the parse logic then feeds the result register as soon as that register is free. one word
// is taken every cycle as long as the receiver keeps taking results; the phase machine
// and its length counters update once per word, which sets the rate at one word per cycle.
// when out_stall holds a result, the input register fills and in_stall rises; no word
// is lost or repeated.
// configuration (buffer capacity, expected type byte) goes through cfg_we, cfg_index and cfg_wdata;
// the user is to write it only while no record is in progress; the block does not enforce this.
// reset clears both pipeline registers, puts the parser back to waiting for a header
// byte, sets the capacity to zero and the expected type to 'T'.
module ndef_text_record_parser_core
	import ntrp_pkg::*;
#(
	parameter int MAX_LANGUAGE_LENGTH = MAX_LANG_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int LW = $clog2(MAX_LANGUAGE_LENGTH + 1);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TYPELEN = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_TYPE    = 3'd3,
		PH_STATUS  = 3'd4,
		PH_LANG    = 3'd5,
		PH_PAYLOAD = 3'd6
	} phase_t;

	logic [15:0] buffer_capacity_q;
	logic [7:0]  expected_type_q;

	in_word_t  word_s1;
	logic      valid_s1;
	out_word_t word_s2;
	logic      valid_s2;
	logic      adv_s2;
	logic      in_take;

	phase_t      phase_q, phase_d;
	logic        short_q, short_d;
	logic [1:0]  lbs_q, lbs_d;
	logic [31:0] rem_q, rem_d;
	logic [LW-1:0] lcnt_q, lcnt_d;
	logic [LW-1:0] ltot_q, ltot_d;
	logic        utf16_q, utf16_d;
	logic [15:0] stored_q, stored_d;

	out_word_t res;
	logic [7:0]  b;
	logic        fin;
	logic [5:0]  llen;
	logic [31:0] rem_dec;
	logic [LW-1:0] lcnt_inc;
	logic [1:0]  lbs_inc;
	logic [31:0] ltot_ext;
	logic        busy;

	assign adv_s2    = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall  = valid_s1 & ~adv_s2;
	assign in_take   = in_valid & ~in_stall;
	assign out_valid = valid_s2;
	assign out_data  = word_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_capacity_q <= CAPACITY_RST;
			expected_type_q   <= EXPECTED_TYPE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUFFER_CAPACITY: buffer_capacity_q <= cfg_wdata[15:0];
				CFG_EXPECTED_TYPE:   expected_type_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take | (valid_s1 & ~adv_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= in_data;
		end
	end

	// parse logic
	always_comb begin
		b        = word_s1.data_byte;
		fin      = word_s1.stream_end;
		llen     = b[5:0];
		rem_dec  = rem_q - 32'd1;
		lcnt_inc = lcnt_q + LW'(1);
		lbs_inc  = lbs_q + 2'd1;
		busy     = (phase_q inside {PH_TYPELEN, PH_LENGTH, PH_TYPE, PH_STATUS, PH_LANG,
			PH_PAYLOAD});

		phase_d  = phase_q;
		short_d  = short_q;
		lbs_d    = lbs_q;
		rem_d    = rem_q;
		lcnt_d   = lcnt_q;
		ltot_d   = ltot_q;
		utf16_d  = utf16_q;
		stored_d = stored_q;

		res             = '0;
		res.byte_class  = CL_FRAME;
		res.out_byte    = b;
		res.error_code  = ERR_NONE;

		if (!busy) begin
			phase_d  = PH_IDLE;
			stored_d = 16'd0;
			utf16_d  = 1'b0;
			ltot_d   = '0;
			if (buffer_capacity_q == 16'd0) begin
				res.byte_class = fin ? CL_END : CL_REJECT;
				res.out_byte   = fin ? 8'd0 : b;
				res.error_code = ERR_NO_BUFFER;
			end else if (fin) begin
				res.byte_class = CL_END;
				res.out_byte   = 8'd0;
				res.error_code = ERR_EARLY_END;
			end else if (b[3] || (b[1:0] != TNF_WELL_KNOWN)) begin
				res.byte_class = CL_REJECT;
				res.error_code = ERR_BAD_HEADER;
			end else begin
				short_d = b[4];
				lbs_d   = 2'd0;
				rem_d   = 32'd0;
				lcnt_d  = '0;
				phase_d = PH_TYPELEN;
			end
		end else if (fin) begin
			phase_d        = PH_IDLE;
			res.byte_class = CL_END;
			res.out_byte   = 8'd0;
			if (phase_q == PH_PAYLOAD && stored_q >= buffer_capacity_q) begin
				res.record_done = 1'b1;
			end else begin
				res.error_code = ERR_EARLY_END;
			end
		end else begin
			case (phase_q)
				PH_TYPELEN: begin
					if (b != TYPE_LEN_ONE) begin
						res.byte_class = CL_REJECT;
						res.error_code = ERR_TYPE_LEN;
						phase_d        = PH_IDLE;
					end else begin
						phase_d = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					rem_d = {rem_q[23:0], b};
					lbs_d = lbs_inc;
					if (short_q || lbs_inc == 2'd0) begin
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					if (b != expected_type_q) begin
						res.byte_class = CL_REJECT;
						res.error_code = ERR_TYPE;
						phase_d        = PH_IDLE;
					end else begin
						phase_d = PH_STATUS;
					end
				end
				PH_STATUS: begin
					if (llen == 6'd0 || b[6]) begin
						res.byte_class = CL_REJECT;
						res.error_code = ERR_STATUS;
						phase_d        = PH_IDLE;
					end else if (32'(llen) > MAX_LANGUAGE_LENGTH) begin
						res.byte_class = CL_REJECT;
						res.error_code = ERR_LANG_LONG;
						phase_d        = PH_IDLE;
					end else if (rem_q < 32'(llen) + 32'd1) begin
						res.byte_class = CL_REJECT;
						res.error_code = ERR_LEN_SHORT;
						phase_d        = PH_IDLE;
					end else begin
						rem_d   = rem_q - 32'(llen) - 32'd1;
						utf16_d = b[7];
						ltot_d  = llen[LW-1:0];
						lcnt_d  = '0;
						phase_d = PH_LANG;
					end
				end
				PH_LANG: begin
					res.byte_class = CL_LANG;
					res.position   = 16'(lcnt_q);
					lcnt_d         = lcnt_inc;
					if (lcnt_inc >= ltot_q) begin
						if (rem_q == 32'd0) begin
							res.record_done = 1'b1;
							phase_d         = PH_IDLE;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					rem_d = rem_dec;
					if (stored_q < buffer_capacity_q) begin
						res.byte_class = CL_STORED;
						res.position   = stored_q;
						stored_d       = stored_q + 16'd1;
					end else begin
						res.byte_class = CL_DISCARD;
					end
					if (rem_dec == 32'd0) begin
						res.record_done = 1'b1;
						phase_d         = PH_IDLE;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end

		ltot_ext            = 32'(ltot_d);
		res.stored_count    = stored_d;
		res.utf16_text      = utf16_d;
		res.language_length = ltot_ext[3:0];
	end

	// phase machine and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			short_q  <= 1'b0;
			lbs_q    <= 2'd0;
			rem_q    <= 32'd0;
			lcnt_q   <= '0;
			ltot_q   <= '0;
			utf16_q  <= 1'b0;
			stored_q <= 16'd0;
			valid_s2 <= 1'b0;
			word_s2  <= '0;
		end else begin
			valid_s2 <= adv_s2 | (valid_s2 & out_stall);
			if (adv_s2) begin
				phase_q  <= phase_d;
				short_q  <= short_d;
				lbs_q    <= lbs_d;
				rem_q    <= rem_d;
				lcnt_q   <= lcnt_d;
				ltot_q   <= ltot_d;
				utf16_q  <= utf16_d;
				stored_q <= stored_d;
				word_s2  <= res;
			end
		end
	end

	a_done_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(word_s2.record_done && word_s2.error_code != ERR_NONE))
		else $error("completed record carries an error code");

	a_stored_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && word_s2.byte_class == CL_STORED) |->
			(word_s2.stored_count == word_s2.position + 16'd1))
		else $error("stored byte position does not match stored count");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && (res.record_done || res.error_code != ERR_NONE)) |=>
			(phase_q == PH_IDLE))
		else $error("parser not idle after completion or error");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while the pipeline can move");

	a_lang_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LANG) |-> (lcnt_q < ltot_q))
		else $error("language index beyond language length");

endmodule

@@ test/tb.sv @@
// testbench for the ndef text record parser: random and directed records checked against a predictor
module tb;
	import ntrp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HDR_SR_BIT  = 4;
	localparam int HDR_IL_BIT  = 3;
	localparam int ST_RSV_BIT  = 6;
	localparam int ST_UTF_BIT  = 7;

	typedef enum logic [2:0] {
		PS_HEADER, PS_TYPE_LEN, PS_LENGTH, PS_TYPE, PS_STATUS, PS_LANG, PS_PAYLOAD
	} parse_state_t;

	typedef logic [7:0] byte_list_t[$];

	class record_scoreboard;
		logic [15:0]  capacity;
		logic [7:0]   type_byte;
		parse_state_t state;
		logic         short_rec;
		logic [1:0]   len_seen;
		logic [31:0]  remaining;
		logic [3:0]   lang_cnt;
		logic [3:0]   lang_tot;
		logic         utf16;
		logic [15:0]  stored;
		out_word_t    expected_q[$];
		int           errors;

		function new();
			capacity  = CAPACITY_RST;
			type_byte = EXPECTED_TYPE_RST;
			state     = PS_HEADER;
			short_rec = 1'b0;
			len_seen  = 2'd0;
			remaining = 32'd0;
			lang_cnt  = 4'd0;
			lang_tot  = 4'd0;
			utf16     = 1'b0;
			stored    = 16'd0;
			errors    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == CFG_BUFFER_CAPACITY)
				capacity = val;
			else if (idx == CFG_EXPECTED_TYPE)
				type_byte = val[7:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function out_word_t make_result(logic [2:0] cls, logic [7:0] b, logic [15:0] pos,
				logic done, logic [3:0] err);
			out_word_t r;
			r.byte_class      = cls;
			r.out_byte        = b;
			r.position        = pos;
			r.record_done     = done;
			r.error_code      = err;
			r.stored_count    = stored;
			r.utf16_text      = utf16;
			r.language_length = lang_tot;
			return r;
		endfunction

		function out_word_t reject(logic [7:0] b, logic [3:0] err);
			state = PS_HEADER;
			return make_result(CL_REJECT, b, 16'd0, 1'b0, err);
		endfunction

		function out_word_t parse_word(in_word_t w);
			logic [7:0]  b;
			logic [5:0]  llen;
			logic [15:0] pos;
			logic        last;
			b = w.data_byte;
			if (state == PS_HEADER) begin
				stored   = 16'd0;
				utf16    = 1'b0;
				lang_tot = 4'd0;
				if (capacity == 16'd0)
					return make_result(w.stream_end ? CL_END : CL_REJECT,
						w.stream_end ? 8'h00 : b, 16'd0, 1'b0, ERR_NO_BUFFER);
				if (w.stream_end)
					return make_result(CL_END, 8'h00, 16'd0, 1'b0, ERR_EARLY_END);
				if (b[HDR_IL_BIT] || b[1:0] != TNF_WELL_KNOWN)
					return reject(b, ERR_BAD_HEADER);
				short_rec = b[HDR_SR_BIT];
				len_seen  = 2'd0;
				remaining = 32'd0;
				lang_cnt  = 4'd0;
				state     = PS_TYPE_LEN;
				return make_result(CL_FRAME, b, 16'd0, 1'b0, ERR_NONE);
			end
			if (w.stream_end) begin
				last  = (state == PS_PAYLOAD) && (stored >= capacity);
				state = PS_HEADER;
				return make_result(CL_END, 8'h00, 16'd0, last, last ? ERR_NONE : ERR_EARLY_END);
			end
			case (state)
				PS_TYPE_LEN: begin
					if (b != TYPE_LEN_ONE)
						return reject(b, ERR_TYPE_LEN);
					state = PS_LENGTH;
					return make_result(CL_FRAME, b, 16'd0, 1'b0, ERR_NONE);
				end
				PS_LENGTH: begin
					remaining = {remaining[23:0], b};
					len_seen  = len_seen + 2'd1;
					if (short_rec || len_seen == 2'd0)
						state = PS_TYPE;
					return make_result(CL_FRAME, b, 16'd0, 1'b0, ERR_NONE);
				end
				PS_TYPE: begin
					if (b != type_byte)
						return reject(b, ERR_TYPE);
					state = PS_STATUS;
					return make_result(CL_FRAME, b, 16'd0, 1'b0, ERR_NONE);
				end
				PS_STATUS: begin
					llen = b[5:0];
					if (llen == 6'd0 || b[ST_RSV_BIT])
						return reject(b, ERR_STATUS);
					if (llen > MAX_LANG_LEN_DEF)
						return reject(b, ERR_LANG_LONG);
					if (remaining < 32'(llen) + 32'd1)
						return reject(b, ERR_LEN_SHORT);
					remaining = remaining - 32'd1 - 32'(llen);
					utf16     = b[ST_UTF_BIT];
					lang_tot  = llen[3:0];
					lang_cnt  = 4'd0;
					state     = PS_LANG;
					return make_result(CL_FRAME, b, 16'd0, 1'b0, ERR_NONE);
				end
				PS_LANG: begin
					pos      = {12'd0, lang_cnt};
					lang_cnt = lang_cnt + 4'd1;
					if (lang_cnt >= lang_tot) begin
						if (remaining == 32'd0) begin
							state = PS_HEADER;
							return make_result(CL_LANG, b, pos, 1'b1, ERR_NONE);
						end
						state = PS_PAYLOAD;
					end
					return make_result(CL_LANG, b, pos, 1'b0, ERR_NONE);
				end
				default: begin
					remaining = remaining - 32'd1;
					last      = (remaining == 32'd0);
					if (last)
						state = PS_HEADER;
					if (stored < capacity) begin
						pos    = stored;
						stored = stored + 16'd1;
						return make_result(CL_STORED, b, pos, last, ERR_NONE);
					end
					return make_result(CL_DISCARD, b, 16'd0, last, ERR_NONE);
				end
			endcase
		endfunction

		function void note_input(in_word_t w);
			expected_q.push_back(parse_word(w));
		endfunction

		function void cmp(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, actual %p", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			cmp("byte_class", 16'(want.byte_class), 16'(got.byte_class));
			cmp("out_byte", 16'(want.out_byte), 16'(got.out_byte));
			cmp("position", want.position, got.position);
			cmp("record_done", 16'(want.record_done), 16'(got.record_done));
			cmp("error_code", 16'(want.error_code), 16'(got.error_code));
			cmp("stored_count", want.stored_count, got.stored_count);
			cmp("utf16_text", 16'(want.utf16_text), 16'(got.utf16_text));
			cmp("language_length", 16'(want.language_length), 16'(got.language_length));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_word_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_word_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	record_scoreboard sb = new();
	int  cycle_count = 0;
	int  words_sent = 0;
	bit  no_idle = 1'b0;
	bit  hold_long_req = 1'b0;

	ndef_text_record_parser_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function int idle_cycles();
		if (no_idle || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function in_word_t byte_word(logic [7:0] b);
		in_word_t w;
		w.data_byte  = b;
		w.stream_end = 1'b0;
		return w;
	endfunction

	function in_word_t end_word();
		in_word_t w;
		w.data_byte  = 8'($urandom);
		w.stream_end = 1'b1;
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(w);
		words_sent++;
	endtask

	task automatic send_bytes(input byte_list_t list);
		foreach (list[i])
			send_word(byte_word(list[i]));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random stall per word, one long hold on request
	initial begin : receiver
		int n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = idle_cycles();
			if (hold_long_req) begin
				hold_long_req = 1'b0;
				n = 300;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	initial begin : stimulus
		in_word_t    words[$];
		in_word_t    w;
		logic [31:0] declared;
		logic [7:0]  hdr;
		bit          sr;
		bit          trunc;
		int          kind, llen, plen, cut, idx, len_idx, type_idx, phase_end;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_BUFFER_CAPACITY;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no buffer after reset
		send_bytes('{8'h00});
		send_word(end_word());
		wait_drained();
		write_cfg(CFG_BUFFER_CAPACITY, 16'd2);
		// end while idle, bad header, type length, status checked before language length
		send_word(end_word());
		send_bytes('{8'h09, 8'hD1, 8'h02, 8'hD1, 8'h01, 8'h04, 8'h54, 8'h7F});
		// empty text in utf-16
		send_bytes('{8'hD1, 8'h01, 8'h03, 8'h54, 8'h82, 8'h65, 8'h6E});
		// overflow into discards, then end while discarding
		send_bytes('{8'hD1, 8'h01, 8'hFF, 8'h54, 8'h01, 8'h65, 8'h41, 8'h42, 8'h43});
		send_word(end_word());
		// capacity lowered in the middle of a record
		send_bytes('{8'hD1, 8'h01, 8'h05, 8'h54, 8'h01, 8'h65, 8'h41});
		wait_drained();
		write_cfg(CFG_BUFFER_CAPACITY, 16'd1);
		send_bytes('{8'h42, 8'h43});

		for (int p = 0; p < 7; p++) begin
			wait_drained();
			case (p)
				0: begin
					write_cfg(CFG_BUFFER_CAPACITY, 16'd4);
					write_cfg(CFG_EXPECTED_TYPE, 16'h0054);
				end
				1: write_cfg(CFG_BUFFER_CAPACITY, 16'hFFFF);
				2: begin
					write_cfg(CFG_BUFFER_CAPACITY, 16'd1);
					write_cfg(CFG_EXPECTED_TYPE, 16'h0000);
				end
				3: begin
					write_cfg(CFG_BUFFER_CAPACITY, 16'($urandom_range(2, 16)));
					write_cfg(CFG_EXPECTED_TYPE, 16'h00FF);
				end
				4: begin
					write_cfg(CFG_BUFFER_CAPACITY, 16'($urandom));
					write_cfg(CFG_EXPECTED_TYPE, 16'($urandom));
				end
				5: begin
					write_cfg(CFG_BUFFER_CAPACITY, 16'd0);
					write_cfg(CFG_EXPECTED_TYPE, 16'h0054);
				end
				default: write_cfg(CFG_BUFFER_CAPACITY, 16'($urandom_range(1, 8)));
			endcase
			no_idle = (p == 2);
			if (p == 1)
				hold_long_req = 1'b1;
			phase_end = words_sent + ((p == 5) ? 40 : 115);
			while (words_sent < phase_end) begin
				if (p == 3 && words_sent >= phase_end - 60 && words_sent < phase_end - 50)
					wait_drained();
				if ($urandom_range(0, 19) == 0) begin
					w.data_byte  = 8'($urandom);
					w.stream_end = ($urandom_range(0, 3) == 0);
					send_word(w);
				end else begin
					words.delete();
					kind = $urandom_range(0, 99);
					sr   = ($urandom_range(0, 3) != 0);
					llen = $urandom_range(1, MAX_LANG_LEN_DEF);
					plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
						: $urandom_range(0, 12);
					declared = 32'(1 + llen + plen);
					trunc = (kind >= 70 && kind < 90);
					if (!sr && $urandom_range(0, 7) == 0) begin
						declared = $urandom();
						trunc = 1'b1;
					end
					hdr = {3'($urandom), sr, 1'b0, 1'($urandom), TNF_WELL_KNOWN};
					words.push_back(byte_word(hdr));
					words.push_back(byte_word(TYPE_LEN_ONE));
					if (sr) begin
						words.push_back(byte_word(declared[7:0]));
					end else begin
						words.push_back(byte_word(declared[31:24]));
						words.push_back(byte_word(declared[23:16]));
						words.push_back(byte_word(declared[15:8]));
						words.push_back(byte_word(declared[7:0]));
					end
					len_idx  = sr ? 2 : 5;
					type_idx = len_idx + 1;
					words.push_back(byte_word(sb.type_byte));
					words.push_back(byte_word({1'($urandom), 1'b0, 6'(llen)}));
					repeat (llen + plen)
						words.push_back(byte_word(8'($urandom)));
					if (kind >= 90) begin
						case ($urandom_range(0, 3))
							0: begin
								idx = $urandom_range(0, words.size() - 1);
								words[idx].data_byte = 8'($urandom);
							end
							1: words[type_idx + 1].data_byte = 8'($urandom);
							2: words[type_idx].data_byte = 8'($urandom);
							default: begin
								for (int i = 2; i < len_idx; i++)
									words[i].data_byte = 8'h00;
								words[len_idx].data_byte = 8'($urandom_range(0, llen));
							end
						endcase
						if ($urandom_range(0, 3) != 0)
							words.push_back(end_word());
					end else if (trunc) begin
						cut = $urandom_range(0, 1) ? words.size()
							: $urandom_range(0, words.size() - 1);
						while (words.size() > cut)
							void'(words.pop_back());
						words.push_back(end_word());
					end
					foreach (words[i])
						send_word(words[i]);
				end
			end
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
